[sv/assert_macros.svh]
// Assertion macros shared by the sequencer RTL.
// Depends on nothing; the including module must provide clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/i2c_seq_pkg.sv]
// Package for the I2C transaction sequencer: payload structs, phase type
// and command and mode codes. Depends on nothing.
package i2c_seq_pkg;

    // Sequencer phase.
    typedef enum logic [3:0] {
        PH_IDLE  = 4'd0,
        PH_ADDRW = 4'd1,
        PH_OFFS  = 4'd2,
        PH_ADDRR = 4'd3,
        PH_WDATA = 4'd4,
        PH_READ  = 4'd5
    } phase_t;

    // Commands to the byte-level core.
    localparam logic [2:0] CMD_NONE   = 3'd0;
    localparam logic [2:0] CMD_STARTW = 3'd1;
    localparam logic [2:0] CMD_WRITE  = 3'd2;
    localparam logic [2:0] CMD_RDACK  = 3'd3;
    localparam logic [2:0] CMD_RDNACK = 3'd4;
    localparam logic [2:0] CMD_STOP   = 3'd5;

    // Transaction modes.
    localparam logic [1:0] MODE_WRITE = 2'd0;
    localparam logic [1:0] MODE_CUR   = 2'd1;
    localparam logic [1:0] MODE_RAND  = 2'd2;
    localparam logic [1:0] MODE_SEQ   = 2'd3;

    // Item kinds.
    localparam logic KIND_REQUEST = 1'b0;
    localparam logic KIND_EVENT   = 1'b1;

    // Direction bit for the read address byte.
    localparam logic [7:0] READ_BIT = 8'h01;

    typedef struct packed {
        logic       kind;
        logic [1:0] mode;
        logic [7:0] device_addr;
        logic [7:0] start_offset;
        logic [7:0] byte_count;
        logic       nack_seen;
        logic [7:0] rx_byte;
        logic [7:0] tx_byte;
    } in_item_t;

    typedef struct packed {
        logic [2:0] command;
        logic [7:0] tx_out;
        logic       rx_valid;
        logic [7:0] rx_out;
        logic       done_res;
        logic       ok;
    } out_item_t;

endpackage

[sv/i2c_transaction_sequencer.sv]
// A transaction taken on the input is held in the input register, then loaded into the output register.
// Throughput: one transaction per cycle unless out_ready stalls the output register; the limit is
// the single stage that updates the phase and counters and loads the output register.
// Reset: rst_n clears the phase to idle, the held mode, address, offset and
// count to zero, and both pipeline valid flags.
// Depends on i2c_seq_pkg and assert_macros.svh.
`include "assert_macros.svh"

module i2c_transaction_sequencer (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  i2c_seq_pkg::in_item_t  in_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output i2c_seq_pkg::out_item_t out_data
);

    // Pipeline registers.
    logic                   in_valid_reg;
    i2c_seq_pkg::in_item_t  in_item_reg;
    logic                   out_valid_reg;
    i2c_seq_pkg::out_item_t out_item_reg;
    logic                   advance;

    // Sequencer state.
    i2c_seq_pkg::phase_t phase_reg, phase_next;
    logic [1:0]          op_mode_reg, op_mode_next;
    logic [7:0]          slave_reg, slave_next;
    logic [7:0]          offset_reg, offset_next;
    logic [7:0]          remaining_reg, remaining_next;
    i2c_seq_pkg::out_item_t result;

    logic       is_event;
    logic       nack;
    logic       rem_zero;
    logic [7:0] rem_dec;

    assign advance   = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || advance;
    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;

    assign is_event = (in_item_reg.kind == i2c_seq_pkg::KIND_EVENT);
    assign nack     = in_item_reg.nack_seen;
    assign rem_zero = (remaining_reg == 8'd0);
    assign rem_dec  = remaining_reg - 8'd1;

    // Valid flags and sequencer state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= i2c_seq_pkg::PH_IDLE;
            op_mode_reg   <= 2'd0;
            slave_reg     <= 8'd0;
            offset_reg    <= 8'd0;
            remaining_reg <= 8'd0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                phase_reg     <= phase_next;
                op_mode_reg   <= op_mode_next;
                slave_reg     <= slave_next;
                offset_reg    <= offset_next;
                remaining_reg <= remaining_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_item_reg <= in_data;
        end
        if (advance)
        begin
            out_item_reg <= result;
        end
    end

    // Next phase, held request fields and byte counter.
    always_comb
    begin
        phase_next     = phase_reg;
        op_mode_next   = op_mode_reg;
        slave_next     = slave_reg;
        offset_next    = offset_reg;
        remaining_next = remaining_reg;
        if (!is_event)
        begin
            if (phase_reg == i2c_seq_pkg::PH_IDLE)
            begin
                op_mode_next   = in_item_reg.mode;
                slave_next     = in_item_reg.device_addr;
                offset_next    = in_item_reg.start_offset;
                remaining_next = in_item_reg.byte_count;
                if ((in_item_reg.mode inside {i2c_seq_pkg::MODE_CUR, i2c_seq_pkg::MODE_RAND}) &&
                    in_item_reg.byte_count == 8'd0)
                begin
                    phase_next = i2c_seq_pkg::PH_IDLE;
                end
                else if (in_item_reg.mode == i2c_seq_pkg::MODE_CUR)
                begin
                    phase_next = i2c_seq_pkg::PH_ADDRR;
                end
                else
                begin
                    phase_next = i2c_seq_pkg::PH_ADDRW;
                end
            end
        end
        else
        begin
            case (phase_reg)
                i2c_seq_pkg::PH_ADDRW:
                begin
                    phase_next = nack ? i2c_seq_pkg::PH_IDLE : i2c_seq_pkg::PH_OFFS;
                end
                i2c_seq_pkg::PH_OFFS:
                begin
                    if (nack)
                    begin
                        phase_next = i2c_seq_pkg::PH_IDLE;
                    end
                    else if (op_mode_reg == i2c_seq_pkg::MODE_WRITE)
                    begin
                        if (rem_zero)
                        begin
                            phase_next = i2c_seq_pkg::PH_IDLE;
                        end
                        else
                        begin
                            remaining_next = rem_dec;
                            phase_next     = i2c_seq_pkg::PH_WDATA;
                        end
                    end
                    else
                    begin
                        phase_next = i2c_seq_pkg::PH_ADDRR;
                    end
                end
                i2c_seq_pkg::PH_WDATA:
                begin
                    if (nack || rem_zero)
                    begin
                        phase_next = i2c_seq_pkg::PH_IDLE;
                    end
                    else
                    begin
                        remaining_next = rem_dec;
                    end
                end
                i2c_seq_pkg::PH_ADDRR:
                begin
                    if (nack || (op_mode_reg == i2c_seq_pkg::MODE_SEQ && rem_zero))
                    begin
                        phase_next = i2c_seq_pkg::PH_IDLE;
                    end
                    else
                    begin
                        if (!rem_zero)
                        begin
                            remaining_next = rem_dec;
                        end
                        phase_next = i2c_seq_pkg::PH_READ;
                    end
                end
                i2c_seq_pkg::PH_READ:
                begin
                    if (op_mode_reg == i2c_seq_pkg::MODE_CUR)
                    begin
                        if (nack || rem_zero)
                        begin
                            phase_next = i2c_seq_pkg::PH_IDLE;
                        end
                        else
                        begin
                            phase_next = i2c_seq_pkg::PH_ADDRR;
                        end
                    end
                    else if (op_mode_reg == i2c_seq_pkg::MODE_RAND)
                    begin
                        offset_next = offset_reg + 8'd1;
                        phase_next  = rem_zero ? i2c_seq_pkg::PH_IDLE
                                               : i2c_seq_pkg::PH_ADDRW;
                    end
                    else if (rem_zero)
                    begin
                        phase_next = i2c_seq_pkg::PH_IDLE;
                    end
                    else
                    begin
                        remaining_next = rem_dec;
                    end
                end
                default:
                begin
                    phase_next = i2c_seq_pkg::PH_IDLE;
                end
            endcase
        end
    end

    // Result for the transaction in the input register.
    always_comb
    begin
        result = '0;
        if (!is_event)
        begin
            if (phase_reg == i2c_seq_pkg::PH_IDLE)
            begin
                if ((in_item_reg.mode inside {i2c_seq_pkg::MODE_CUR, i2c_seq_pkg::MODE_RAND}) &&
                    in_item_reg.byte_count == 8'd0)
                begin
                    result.command  = i2c_seq_pkg::CMD_STOP;
                    result.done_res = 1'b1;
                    result.ok       = 1'b1;
                end
                else if (in_item_reg.mode == i2c_seq_pkg::MODE_CUR)
                begin
                    result.command = i2c_seq_pkg::CMD_STARTW;
                    result.tx_out  = in_item_reg.device_addr | i2c_seq_pkg::READ_BIT;
                end
                else
                begin
                    result.command = i2c_seq_pkg::CMD_STARTW;
                    result.tx_out  = in_item_reg.device_addr;
                end
            end
        end
        else
        begin
            case (phase_reg)
                i2c_seq_pkg::PH_ADDRW:
                begin
                    if (nack)
                    begin
                        result.command  = i2c_seq_pkg::CMD_STOP;
                        result.done_res = 1'b1;
                    end
                    else
                    begin
                        result.command = i2c_seq_pkg::CMD_WRITE;
                        result.tx_out  = offset_reg;
                    end
                end
                i2c_seq_pkg::PH_OFFS:
                begin
                    if (nack)
                    begin
                        result.command  = i2c_seq_pkg::CMD_STOP;
                        result.done_res = 1'b1;
                    end
                    else if (op_mode_reg == i2c_seq_pkg::MODE_WRITE)
                    begin
                        if (rem_zero)
                        begin
                            result.command  = i2c_seq_pkg::CMD_STOP;
                            result.done_res = 1'b1;
                            result.ok       = 1'b1;
                        end
                        else
                        begin
                            result.command = i2c_seq_pkg::CMD_WRITE;
                            result.tx_out  = in_item_reg.tx_byte;
                        end
                    end
                    else
                    begin
                        result.command = i2c_seq_pkg::CMD_STARTW;
                        result.tx_out  = slave_reg | i2c_seq_pkg::READ_BIT;
                    end
                end
                i2c_seq_pkg::PH_WDATA:
                begin
                    if (nack || rem_zero)
                    begin
                        result.command  = i2c_seq_pkg::CMD_STOP;
                        result.done_res = 1'b1;
                        result.ok       = !nack;
                    end
                    else
                    begin
                        result.command = i2c_seq_pkg::CMD_WRITE;
                        result.tx_out  = in_item_reg.tx_byte;
                    end
                end
                i2c_seq_pkg::PH_ADDRR:
                begin
                    if (nack || (op_mode_reg == i2c_seq_pkg::MODE_SEQ && rem_zero))
                    begin
                        result.command  = i2c_seq_pkg::CMD_STOP;
                        result.done_res = 1'b1;
                        result.ok       = !nack;
                    end
                    else if (op_mode_reg == i2c_seq_pkg::MODE_SEQ && rem_dec != 8'd0)
                    begin
                        result.command = i2c_seq_pkg::CMD_RDACK;
                    end
                    else
                    begin
                        result.command = i2c_seq_pkg::CMD_RDNACK;
                    end
                end
                i2c_seq_pkg::PH_READ:
                begin
                    // A current read drops the byte on a missing acknowledge.
                    if (op_mode_reg == i2c_seq_pkg::MODE_CUR && nack)
                    begin
                        result.command  = i2c_seq_pkg::CMD_STOP;
                        result.done_res = 1'b1;
                    end
                    else
                    begin
                        result.rx_valid = 1'b1;
                        result.rx_out   = in_item_reg.rx_byte;
                        if (rem_zero)
                        begin
                            result.command  = i2c_seq_pkg::CMD_STOP;
                            result.done_res = 1'b1;
                            result.ok       = 1'b1;
                        end
                        else if (op_mode_reg == i2c_seq_pkg::MODE_CUR)
                        begin
                            result.command = i2c_seq_pkg::CMD_STARTW;
                            result.tx_out  = slave_reg | i2c_seq_pkg::READ_BIT;
                        end
                        else if (op_mode_reg == i2c_seq_pkg::MODE_RAND)
                        begin
                            result.command = i2c_seq_pkg::CMD_STARTW;
                            result.tx_out  = slave_reg;
                        end
                        else if (rem_dec != 8'd0)
                        begin
                            result.command = i2c_seq_pkg::CMD_RDACK;
                        end
                        else
                        begin
                            result.command = i2c_seq_pkg::CMD_RDNACK;
                        end
                    end
                end
                default:
                begin
                    result = '0;
                end
            endcase
        end
    end

    // Checks on the sequencer logic.
    `ASSERT_NEXT(a_done_goes_idle, advance && result.done_res, phase_reg == i2c_seq_pkg::PH_IDLE, "done without return to idle")
    `ASSERT_IMPL(a_rx_only_in_read, advance && result.rx_valid, is_event && phase_reg == i2c_seq_pkg::PH_READ, "read byte delivered outside the read phase")
    `ASSERT_IMPL(a_ok_needs_done, out_valid_reg && out_item_reg.ok, out_item_reg.done_res && out_item_reg.command == i2c_seq_pkg::CMD_STOP, "ok flagged without a stop")
    `ASSERT_IMPL(a_ready_when_empty, !out_valid_reg, in_ready, "input stalled with an empty output register")

endmodule

[tb/tb_top.sv]
// Self-checking testbench for the I2C transaction sequencer: a scripted
// opening followed by random transactions, checked against hand-typed results or a behavioral predictor.
// Depends on i2c_seq_pkg and the i2c_transaction_sequencer RTL.
module tb_top;

    // One row of the scripted opening: the stimulus and, where it is obvious,
    // the result typed in by hand.
    typedef struct {
        i2c_seq_pkg::in_item_t  stim;
        bit                     typed;
        i2c_seq_pkg::out_item_t want;
    } script_row_t;

    localparam int SCRIPT_LEN   = 27;
    localparam int RANDOM_ITEMS = 500;
    localparam int HOLD_AT      = 200;
    localparam int HOLD_CYCLES  = 400;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_ready;
    i2c_seq_pkg::in_item_t  in_data;
    logic                   out_valid;
    logic                   out_ready;
    i2c_seq_pkg::out_item_t out_data;

    // Predictor state.
    i2c_seq_pkg::phase_t seq_phase;
    logic [1:0]          seq_mode;
    logic [7:0]          seq_addr;
    logic [7:0]          seq_offset;
    logic [7:0]          seq_left;

    i2c_seq_pkg::out_item_t pending_results[$];
    script_row_t            script[SCRIPT_LEN];
    int                     err_count = 0;
    int                     checked_count = 0;
    int                     random_items = 0;
    bit                     sender_calm = 1'b0;
    bit                     receiver_calm = 1'b0;

    i2c_transaction_sequencer u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // Clock with a period of 20 time units.
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Ends the transaction with a stop, carrying done and the success flag.
    function automatic void close_txn(inout i2c_seq_pkg::out_item_t r, input logic good);
        r.command  = i2c_seq_pkg::CMD_STOP;
        r.tx_out   = '0;
        r.done_res = 1'b1;
        r.ok       = good;
        seq_phase  = i2c_seq_pkg::PH_IDLE;
    endfunction

    // Issues one sequential read byte: ACK unless it is the last one.
    function automatic void next_seq_read(inout i2c_seq_pkg::out_item_t r);
        seq_left  = seq_left - 8'd1;
        r.command = (seq_left != 8'd0) ? i2c_seq_pkg::CMD_RDACK : i2c_seq_pkg::CMD_RDNACK;
        r.tx_out  = '0;
        seq_phase = i2c_seq_pkg::PH_READ;
    endfunction

    // Computes the result of one transaction item and advances the predictor.
    function automatic i2c_seq_pkg::out_item_t next_response(input i2c_seq_pkg::in_item_t it);
        i2c_seq_pkg::out_item_t r;
        r = '0;
        if (it.kind == i2c_seq_pkg::KIND_REQUEST)
        begin
            // A request while busy is dropped without touching the state.
            if (seq_phase != i2c_seq_pkg::PH_IDLE)
                return r;
            seq_mode   = it.mode;
            seq_addr   = it.device_addr;
            seq_offset = it.start_offset;
            seq_left   = it.byte_count;
            if ((seq_mode inside {i2c_seq_pkg::MODE_CUR, i2c_seq_pkg::MODE_RAND}) &&
                seq_left == 8'd0)
                close_txn(r, 1'b1);
            else if (seq_mode == i2c_seq_pkg::MODE_CUR)
            begin
                r.command = i2c_seq_pkg::CMD_STARTW;
                r.tx_out  = seq_addr | i2c_seq_pkg::READ_BIT;
                seq_phase = i2c_seq_pkg::PH_ADDRR;
            end
            else
            begin
                r.command = i2c_seq_pkg::CMD_STARTW;
                r.tx_out  = seq_addr;
                seq_phase = i2c_seq_pkg::PH_ADDRW;
            end
            return r;
        end
        case (seq_phase)
            i2c_seq_pkg::PH_ADDRW:
            begin
                if (it.nack_seen)
                    close_txn(r, 1'b0);
                else
                begin
                    r.command = i2c_seq_pkg::CMD_WRITE;
                    r.tx_out  = seq_offset;
                    seq_phase = i2c_seq_pkg::PH_OFFS;
                end
            end
            i2c_seq_pkg::PH_OFFS:
            begin
                if (it.nack_seen)
                    close_txn(r, 1'b0);
                else if (seq_mode == i2c_seq_pkg::MODE_WRITE)
                begin
                    if (seq_left == 8'd0)
                        close_txn(r, 1'b1);
                    else
                    begin
                        seq_left  = seq_left - 8'd1;
                        r.command = i2c_seq_pkg::CMD_WRITE;
                        r.tx_out  = it.tx_byte;
                        seq_phase = i2c_seq_pkg::PH_WDATA;
                    end
                end
                else
                begin
                    r.command = i2c_seq_pkg::CMD_STARTW;
                    r.tx_out  = seq_addr | i2c_seq_pkg::READ_BIT;
                    seq_phase = i2c_seq_pkg::PH_ADDRR;
                end
            end
            i2c_seq_pkg::PH_WDATA:
            begin
                if (it.nack_seen)
                    close_txn(r, 1'b0);
                else if (seq_left == 8'd0)
                    close_txn(r, 1'b1);
                else
                begin
                    seq_left  = seq_left - 8'd1;
                    r.command = i2c_seq_pkg::CMD_WRITE;
                    r.tx_out  = it.tx_byte;
                end
            end
            i2c_seq_pkg::PH_ADDRR:
            begin
                if (it.nack_seen)
                    close_txn(r, 1'b0);
                else if (seq_mode == i2c_seq_pkg::MODE_SEQ)
                begin
                    if (seq_left == 8'd0)
                        close_txn(r, 1'b1);
                    else
                        next_seq_read(r);
                end
                else
                begin
                    if (seq_left != 8'd0)
                        seq_left = seq_left - 8'd1;
                    r.command = i2c_seq_pkg::CMD_RDNACK;
                    seq_phase = i2c_seq_pkg::PH_READ;
                end
            end
            i2c_seq_pkg::PH_READ:
            begin
                if (seq_mode == i2c_seq_pkg::MODE_CUR)
                begin
                    // A missing acknowledge on a current read drops the byte.
                    if (it.nack_seen)
                        close_txn(r, 1'b0);
                    else
                    begin
                        r.rx_valid = 1'b1;
                        r.rx_out   = it.rx_byte;
                        if (seq_left == 8'd0)
                            close_txn(r, 1'b1);
                        else
                        begin
                            r.command = i2c_seq_pkg::CMD_STARTW;
                            r.tx_out  = seq_addr | i2c_seq_pkg::READ_BIT;
                            seq_phase = i2c_seq_pkg::PH_ADDRR;
                        end
                    end
                end
                else if (seq_mode == i2c_seq_pkg::MODE_RAND)
                begin
                    r.rx_valid = 1'b1;
                    r.rx_out   = it.rx_byte;
                    seq_offset = seq_offset + 8'd1;
                    if (seq_left == 8'd0)
                        close_txn(r, 1'b1);
                    else
                    begin
                        r.command = i2c_seq_pkg::CMD_STARTW;
                        r.tx_out  = seq_addr;
                        seq_phase = i2c_seq_pkg::PH_ADDRW;
                    end
                end
                else
                begin
                    r.rx_valid = 1'b1;
                    r.rx_out   = it.rx_byte;
                    if (seq_left == 8'd0)
                        close_txn(r, 1'b1);
                    else
                        next_seq_read(r);
                end
            end
            default:
                seq_phase = i2c_seq_pkg::PH_IDLE;
        endcase
        return r;
    endfunction

    function automatic i2c_seq_pkg::in_item_t req_item(input logic [1:0] mode,
                                                       input logic [7:0] addr,
                                                       input logic [7:0] offs,
                                                       input logic [7:0] cnt);
        i2c_seq_pkg::in_item_t it;
        it              = '0;
        it.kind         = i2c_seq_pkg::KIND_REQUEST;
        it.mode         = mode;
        it.device_addr  = addr;
        it.start_offset = offs;
        it.byte_count   = cnt;
        return it;
    endfunction

    function automatic i2c_seq_pkg::in_item_t evt_item(input logic nack, input logic [7:0] rx,
                                                       input logic [7:0] tx);
        i2c_seq_pkg::in_item_t it;
        it           = '0;
        it.kind      = i2c_seq_pkg::KIND_EVENT;
        it.nack_seen = nack;
        it.rx_byte   = rx;
        it.tx_byte   = tx;
        return it;
    endfunction

    function automatic i2c_seq_pkg::out_item_t reply(input logic [2:0] cmd,
                                                     input logic [7:0] tx,
                                                     input logic done, input logic good);
        i2c_seq_pkg::out_item_t r;
        r          = '0;
        r.command  = cmd;
        r.tx_out   = tx;
        r.done_res = done;
        r.ok       = good;
        return r;
    endfunction

    // Every field random; the caller fixes the ones that matter.
    function automatic i2c_seq_pkg::in_item_t scramble_item();
        i2c_seq_pkg::in_item_t it;
        it.kind         = 1'($urandom_range(0, 1));
        it.mode         = 2'($urandom_range(0, 3));
        it.device_addr  = 8'($urandom_range(0, 255));
        it.start_offset = 8'($urandom_range(0, 255));
        it.byte_count   = 8'($urandom_range(0, 255));
        it.nack_seen    = 1'($urandom_range(0, 1));
        it.rx_byte      = 8'($urandom_range(0, 255));
        it.tx_byte      = 8'($urandom_range(0, 255));
        return it;
    endfunction

    // Offers one transaction after a random gap, waits for it to be taken and
    // queues its expected result. Called right after a rising edge.
    task automatic offer(input i2c_seq_pkg::in_item_t it, input bit typed,
                         input i2c_seq_pkg::out_item_t want);
        int                     gap;
        i2c_seq_pkg::out_item_t predicted;
        if ($urandom_range(0, 29) == 0)
            sender_calm = !sender_calm;
        gap = sender_calm ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predicted = next_response(it);
        pending_results.push_back(typed ? want : predicted);
    endtask

    // One random transaction: a request followed by byte-done events until
    // the predictor is idle again, with the odd request while busy mixed in.
    task automatic random_transaction();
        i2c_seq_pkg::in_item_t it;
        int                    pick;
        it      = scramble_item();
        it.kind = i2c_seq_pkg::KIND_REQUEST;
        pick    = $urandom_range(0, 49);
        if (pick == 0 &&
            (it.mode == i2c_seq_pkg::MODE_WRITE || it.mode == i2c_seq_pkg::MODE_SEQ))
            it.byte_count = 8'($urandom_range(0, 255));
        else if (pick < 10)
            it.byte_count = 8'($urandom_range(6, 16));
        else
            it.byte_count = 8'($urandom_range(0, 5));
        offer(it, 1'b0, '0);
        random_items++;
        while (seq_phase != i2c_seq_pkg::PH_IDLE)
        begin
            if ($urandom_range(0, 19) == 0)
            begin
                it      = scramble_item();
                it.kind = i2c_seq_pkg::KIND_REQUEST;
                offer(it, 1'b0, '0);
            end
            it           = scramble_item();
            it.kind      = i2c_seq_pkg::KIND_EVENT;
            it.nack_seen = ($urandom_range(0, 24) == 0);
            offer(it, 1'b0, '0);
            random_items++;
        end
    endtask

    task automatic check_field(input string fname, input logic [7:0] want,
                               input logic [7:0] seen);
        if (want !== seen)
        begin
            $display("%0t: mismatch on %s: expected %0h, actual %0h", $time, fname, want, seen);
            err_count++;
        end
    endtask

    // Main sequence: reset, scripted opening, random transactions, drain.
    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_data    = '0;
        seq_phase  = i2c_seq_pkg::PH_IDLE;
        seq_mode   = '0;
        seq_addr   = '0;
        seq_offset = '0;
        seq_left   = '0;

        // Event while idle, then a long write cut short by a data NACK,
        // with a request while busy in between.
        script[0]  = '{evt_item(1'b1, 8'hFF, 8'hFF), 1'b1,
                       reply(i2c_seq_pkg::CMD_NONE, 8'h00, 1'b0, 1'b0)};
        script[1]  = '{req_item(i2c_seq_pkg::MODE_WRITE, 8'hFF, 8'h00, 8'hFF), 1'b1,
                       reply(i2c_seq_pkg::CMD_STARTW, 8'hFF, 1'b0, 1'b0)};
        script[2]  = '{req_item(i2c_seq_pkg::MODE_SEQ, 8'h12, 8'h34, 8'h01), 1'b1,
                       reply(i2c_seq_pkg::CMD_NONE, 8'h00, 1'b0, 1'b0)};
        script[3]  = '{evt_item(1'b0, 8'h00, 8'h00), 1'b0, '0};
        script[4]  = '{evt_item(1'b0, 8'h00, 8'hFF), 1'b0, '0};
        script[5]  = '{evt_item(1'b1, 8'h00, 8'h00), 1'b1,
                       reply(i2c_seq_pkg::CMD_STOP, 8'h00, 1'b1, 1'b0)};
        // Zero-count current read stops at once; zero-count sequential read
        // sends its whole header first.
        script[6]  = '{req_item(i2c_seq_pkg::MODE_CUR, 8'h00, 8'h00, 8'h00), 1'b1,
                       reply(i2c_seq_pkg::CMD_STOP, 8'h00, 1'b1, 1'b1)};
        script[7]  = '{req_item(i2c_seq_pkg::MODE_SEQ, 8'h50, 8'h10, 8'h00), 1'b1,
                       reply(i2c_seq_pkg::CMD_STARTW, 8'h50, 1'b0, 1'b0)};
        script[8]  = '{evt_item(1'b0, 8'h00, 8'h00), 1'b0, '0};
        script[9]  = '{evt_item(1'b0, 8'h00, 8'h00), 1'b0, '0};
        script[10] = '{evt_item(1'b0, 8'h00, 8'h00), 1'b1,
                       reply(i2c_seq_pkg::CMD_STOP, 8'h00, 1'b1, 1'b1)};
        // Current read whose data byte is not acknowledged.
        script[11] = '{req_item(i2c_seq_pkg::MODE_CUR, 8'h42, 8'h00, 8'h01), 1'b1,
                       reply(i2c_seq_pkg::CMD_STARTW, 8'h43, 1'b0, 1'b0)};
        script[12] = '{evt_item(1'b0, 8'h00, 8'h00), 1'b0, '0};
        script[13] = '{evt_item(1'b1, 8'hAA, 8'h00), 1'b1,
                       reply(i2c_seq_pkg::CMD_STOP, 8'h00, 1'b1, 1'b0)};
        // Random read at the top offset; the NACK on the data byte is ignored.
        script[14] = '{req_item(i2c_seq_pkg::MODE_RAND, 8'h30, 8'hFF, 8'h01), 1'b1,
                       reply(i2c_seq_pkg::CMD_STARTW, 8'h30, 1'b0, 1'b0)};
        script[15] = '{evt_item(1'b0, 8'h00, 8'h00), 1'b0, '0};
        script[16] = '{evt_item(1'b0, 8'h00, 8'h00), 1'b0, '0};
        script[17] = '{evt_item(1'b0, 8'h00, 8'h00), 1'b0, '0};
        script[18] = '{evt_item(1'b1, 8'h5A, 8'h00), 1'b0, '0};
        // NACK on the address byte of a write.
        script[19] = '{req_item(i2c_seq_pkg::MODE_WRITE, 8'h00, 8'h00, 8'h01), 1'b1,
                       reply(i2c_seq_pkg::CMD_STARTW, 8'h00, 1'b0, 1'b0)};
        script[20] = '{evt_item(1'b1, 8'h00, 8'h00), 1'b1,
                       reply(i2c_seq_pkg::CMD_STOP, 8'h00, 1'b1, 1'b0)};
        // 16-bit read: sequential read of two bytes.
        script[21] = '{req_item(i2c_seq_pkg::MODE_SEQ, 8'hA0, 8'h00, 8'h02), 1'b1,
                       reply(i2c_seq_pkg::CMD_STARTW, 8'hA0, 1'b0, 1'b0)};
        script[22] = '{evt_item(1'b0, 8'h00, 8'h00), 1'b0, '0};
        script[23] = '{evt_item(1'b0, 8'h00, 8'h00), 1'b0, '0};
        script[24] = '{evt_item(1'b0, 8'h00, 8'h00), 1'b0, '0};
        script[25] = '{evt_item(1'b0, 8'hC3, 8'h00), 1'b0, '0};
        script[26] = '{evt_item(1'b0, 8'h3C, 8'h00), 1'b0, '0};

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < SCRIPT_LEN; i++)
            offer(script[i].stim, script[i].typed, script[i].want);

        while (random_items < RANDOM_ITEMS)
        begin
            // Occasional byte-done event with no transaction open.
            if ($urandom_range(0, 9) == 0)
            begin
                offer(evt_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                               8'($urandom_range(0, 255))), 1'b0, '0);
            end
            random_transaction();
        end
        in_valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (err_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Result side: random stalls, one long hold-off to fill the block, and a
    // field-by-field check against the oldest expected result.
    initial
    begin
        int                     stall;
        i2c_seq_pkg::out_item_t want;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 29) == 0)
                receiver_calm = !receiver_calm;
            stall = receiver_calm ? 0 : $urandom_range(0, 11);
            if (checked_count == HOLD_AT)
                stall = HOLD_CYCLES;
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            checked_count++;
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %0h", $time, out_data);
                err_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("command", 8'(want.command), 8'(out_data.command));
                check_field("tx_out", want.tx_out, out_data.tx_out);
                check_field("rx_valid", 8'(want.rx_valid), 8'(out_data.rx_valid));
                check_field("rx_out", want.rx_out, out_data.rx_out);
                check_field("done_res", 8'(want.done_res), 8'(out_data.done_res));
                check_field("ok", 8'(want.ok), 8'(out_data.ok));
            end
        end
    end

    // Watchdog.
    initial
    begin
        #6000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
